/* design/wsfd_pkg.sv */
// ---------------------------------------------------------------------------
// wsfd_pkg
// Shared types and constants for the websocket frame deframer.
// ---------------------------------------------------------------------------
package wsfd_pkg;

    // width of the length accumulator (the largest extended length)
    localparam int ACC_BITS = 64;
    // width of the reported payload length
    localparam int OUT_LEN_BITS = 32;

    // seven-bit length codes that announce extension bytes
    localparam logic [6:0] LEN7_EXT64 = 7'h7F;
    localparam logic [6:0] LEN7_EXT16 = 7'h7E;

    // number of extension and masking key bytes
    localparam logic [3:0] EXT_BYTES_64   = 4'd8;
    localparam logic [3:0] EXT_BYTES_16   = 4'd2;
    localparam logic [2:0] MASK_KEY_BYTES = 3'd4;

    // known opcodes
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // kind of a result word
    typedef enum logic [1:0] {
        KIND_HEADER    = 2'd0,
        KIND_PAYLOAD   = 2'd1,
        KIND_BAD_OPCODE = 2'd2,
        KIND_TOO_LARGE = 2'd3
    } kind_t;

    // one result word
    typedef struct packed {
        kind_t       kind;
        logic        fin;
        logic [2:0]  rsv_bits;
        logic [3:0]  opcode;
        logic        masked;
        logic [OUT_LEN_BITS-1:0] frame_length;
        logic [7:0]  payload_byte;
        logic        last_in_frame;
    } result_t;

endpackage

/* design/websocket_frame_deframer_top.sv */
// ---------------------------------------------------------------------------
// websocket_frame_deframer_top
// Splits a received byte stream into websocket frames.
// ---------------------------------------------------------------------------
// Takes one byte per cycle when neither side stalls and gives at most one
// result word per byte: a header word once the header is complete, one word
// per unmasked payload byte (tlast on the final one, or on the header of an
// empty frame), or an error word for an unknown opcode or a length of
// 2**LENGTH_BITS or more, after which parsing restarts at the next byte. The
// parser updates its state once per byte; the input register feeds the
// parser, whose result is captured by the result register. Both sides stall
// independently without loss.
module websocket_frame_deframer_top #(
    parameter int LENGTH_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // fin, rsv_bits[2:0], opcode[3:0], masked,
                                   // frame_length[31:0], payload_byte[7:0], zeros
    output logic [1:0]  m_tuser,   // result_kind[1:0]
    output logic        m_tlast    // last_in_frame
);

    logic              in_valid;
    logic [7:0]        in_byte;
    logic              can_load;
    logic              step;
    logic              res_valid;
    wsfd_pkg::result_t res;

    // a byte is processed when the result register has room
    assign step = in_valid && can_load;

    wsfd_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .take      (can_load),
        .valid     (in_valid),
        .data_byte (in_byte)
    );

    wsfd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step),
        .data_byte (in_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    wsfd_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step && res_valid),
        .res      (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* design/wsfd_in_reg.sv */
// ---------------------------------------------------------------------------
// wsfd_in_reg
// Input register: holds one received byte until the parser takes it.
// ---------------------------------------------------------------------------
module wsfd_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // data_byte [7:0]
    input  logic       take,
    output logic       valid,
    output logic [7:0] data_byte
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    // room when empty or when the held byte leaves this cycle
    assign s_tready  = !valid_reg || take;
    assign valid     = valid_reg;
    assign data_byte = byte_reg;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

endmodule

/* design/wsfd_parser.sv */
// ---------------------------------------------------------------------------
// wsfd_parser
// Frame state machine: one byte per step, at most one result per byte.
// ---------------------------------------------------------------------------
module wsfd_parser #(
    parameter int LENGTH_BITS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [7:0]        data_byte,
    output logic              res_valid,
    output wsfd_pkg::result_t res
);

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXT     = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [3:0]                      ext_left_reg, ext_left_next;
    logic [wsfd_pkg::ACC_BITS-1:0]   acc_reg, acc_next;
    logic [31:0]                     key_reg, key_next;
    logic [2:0]                      mask_left_reg, mask_left_next;
    logic                            mask_flag_reg, mask_flag_next;
    logic [7:0]                      hdr_reg, hdr_next;
    logic [LENGTH_BITS-1:0]          remain_reg, remain_next;
    logic [1:0]                      idx_reg, idx_next;

    logic                            after_len;
    logic                            finish;
    logic                            op_known;
    logic [7:0]                      key_byte;
    logic [6:0]                      len7;

    // saturate the accumulator to the reported length width
    function automatic logic [wsfd_pkg::OUT_LEN_BITS-1:0] sat_len(
        input logic [wsfd_pkg::ACC_BITS-1:0] v
    );
        if (|v[wsfd_pkg::ACC_BITS-1:wsfd_pkg::OUT_LEN_BITS]) begin
            return '1;
        end
        return v[wsfd_pkg::OUT_LEN_BITS-1:0];
    endfunction

    assign len7 = data_byte[6:0];

    // known opcode check on the stored first header byte
    assign op_known = (hdr_reg[3:0] == wsfd_pkg::OP_TEXT)
                   || (hdr_reg[3:0] == wsfd_pkg::OP_BINARY)
                   || (hdr_reg[3:0] == wsfd_pkg::OP_CLOSE)
                   || (hdr_reg[3:0] == wsfd_pkg::OP_PING)
                   || (hdr_reg[3:0] == wsfd_pkg::OP_PONG);

    // key byte in rotation, first key byte in the top bits
    always_comb begin
        unique case (idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // next state and result
    always_comb begin
        phase_next     = phase_reg;
        ext_left_next  = ext_left_reg;
        acc_next       = acc_reg;
        key_next       = key_reg;
        mask_left_next = mask_left_reg;
        mask_flag_next = mask_flag_reg;
        hdr_next       = hdr_reg;
        remain_next    = remain_reg;
        idx_next       = idx_reg;
        after_len      = 1'b0;
        finish         = 1'b0;

        res_valid          = 1'b0;
        res.kind           = wsfd_pkg::KIND_HEADER;
        res.fin            = hdr_reg[7];
        res.rsv_bits       = hdr_reg[6:4];
        res.opcode         = hdr_reg[3:0];
        res.masked         = 1'b0;
        res.frame_length   = '0;
        res.payload_byte   = '0;
        res.last_in_frame  = 1'b0;

        unique case (phase_reg)
            PH_HDR1: begin
                if (!op_known) begin
                    phase_next = PH_HDR0;
                    res_valid  = 1'b1;
                    res.kind   = wsfd_pkg::KIND_BAD_OPCODE;
                end else begin
                    mask_flag_next = data_byte[7];
                    acc_next       = '0;
                    if (len7 == wsfd_pkg::LEN7_EXT64) begin
                        ext_left_next = wsfd_pkg::EXT_BYTES_64;
                        phase_next    = PH_EXT;
                    end else if (len7 == wsfd_pkg::LEN7_EXT16) begin
                        ext_left_next = wsfd_pkg::EXT_BYTES_16;
                        phase_next    = PH_EXT;
                    end else begin
                        acc_next  = {{(wsfd_pkg::ACC_BITS-7){1'b0}}, len7};
                        after_len = 1'b1;
                    end
                end
            end
            PH_EXT: begin
                acc_next = {acc_reg[wsfd_pkg::ACC_BITS-9:0], data_byte};
                if (ext_left_reg != '0) begin
                    ext_left_next = ext_left_reg - 4'd1;
                end
                if (ext_left_reg <= 4'd1) begin
                    if (|(acc_next >> LENGTH_BITS)) begin
                        phase_next         = PH_HDR0;
                        res_valid          = 1'b1;
                        res.kind           = wsfd_pkg::KIND_TOO_LARGE;
                        res.masked         = mask_flag_reg;
                        res.frame_length   = sat_len(acc_next);
                    end else begin
                        after_len = 1'b1;
                    end
                end
            end
            PH_MASK: begin
                key_next = {key_reg[23:0], data_byte};
                if (mask_left_reg != '0) begin
                    mask_left_next = mask_left_reg - 3'd1;
                end
                if (mask_left_reg <= 3'd1) begin
                    finish = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                idx_next    = idx_reg + 2'd1;
                remain_next = remain_reg - 1'b1;
                res_valid          = 1'b1;
                res.kind           = wsfd_pkg::KIND_PAYLOAD;
                res.masked         = mask_flag_reg;
                res.frame_length   = sat_len(acc_reg);
                res.payload_byte   = mask_flag_reg ? (data_byte ^ key_byte) : data_byte;
                res.last_in_frame  = (remain_reg <= 1);
                if (remain_reg <= 1) begin
                    remain_next = '0;
                    phase_next  = PH_HDR0;
                end
            end
            default: begin
                // first header byte, also taken for unused phase codes
                hdr_next       = data_byte;
                mask_flag_next = 1'b0;
                phase_next     = PH_HDR1;
            end
        endcase

        // length known: masking key next, or header done
        if (after_len) begin
            if (mask_flag_next) begin
                mask_left_next = wsfd_pkg::MASK_KEY_BYTES;
                phase_next     = PH_MASK;
            end else begin
                finish = 1'b1;
            end
        end

        // header result, empty frame ends right here
        if (finish) begin
            res_valid  = 1'b1;
            res.kind   = wsfd_pkg::KIND_HEADER;
            res.masked = mask_flag_next;
            if (acc_next == '0) begin
                phase_next        = PH_HDR0;
                res.last_in_frame = 1'b1;
            end else begin
                phase_next         = PH_PAYLOAD;
                remain_next        = acc_next[LENGTH_BITS-1:0];
                idx_next           = 2'd0;
                res.frame_length   = sat_len(acc_next);
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HDR0;
            ext_left_reg  <= '0;
            acc_reg       <= '0;
            key_reg       <= '0;
            mask_left_reg <= '0;
            mask_flag_reg <= 1'b0;
            hdr_reg       <= '0;
            remain_reg    <= '0;
            idx_reg       <= '0;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            ext_left_reg  <= ext_left_next;
            acc_reg       <= acc_next;
            key_reg       <= key_next;
            mask_left_reg <= mask_left_next;
            mask_flag_reg <= mask_flag_next;
            hdr_reg       <= hdr_next;
            remain_reg    <= remain_next;
            idx_reg       <= idx_next;
        end
    end

    // payload phase always has bytes left to count
    a_remain_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> remain_reg != '0)
        else $error("payload phase with zero bytes remaining");

    // extension phase always has bytes left to read
    a_ext_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_EXT |-> ext_left_reg != '0)
        else $error("extension phase with no bytes left");

    // an error result restarts parsing at the next byte
    a_error_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && res_valid && (res.kind == wsfd_pkg::KIND_BAD_OPCODE
            || res.kind == wsfd_pkg::KIND_TOO_LARGE) |=> phase_reg == PH_HDR0)
        else $error("error result did not restart parsing");

    // empty frame header carries the end mark
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.kind == wsfd_pkg::KIND_HEADER && res.frame_length == '0
            |-> res.last_in_frame)
        else $error("empty frame header without end mark");

endmodule

/* design/wsfd_out_reg.sv */
// ---------------------------------------------------------------------------
// wsfd_out_reg
// Result register: holds one result word until the sink takes it.
// ---------------------------------------------------------------------------
module wsfd_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  wsfd_pkg::result_t res,
    output logic              can_load,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [55:0]       m_tdata,  // fin, rsv_bits[2:0], opcode[3:0], masked,
                                        // frame_length[31:0], payload_byte[7:0], zeros
    output logic [1:0]        m_tuser,  // result_kind[1:0]
    output logic              m_tlast   // last_in_frame
);

    logic              valid_reg;
    wsfd_pkg::result_t res_reg;

    // free when empty or when the held word leaves this cycle
    assign can_load = !valid_reg || m_tready;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (load && can_load) begin
            res_reg <= res;
        end
    end

    // port packing
    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'b0, res_reg.payload_byte, res_reg.frame_length,
                       res_reg.masked, res_reg.opcode, res_reg.rsv_bits, res_reg.fin};
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last_in_frame;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for websocket_frame_deframer_top.
// ---------------------------------------------------------------------------
// Feeds a byte stream of well-formed frames with random content and a share
// of broken headers. A scoreboard class parses every accepted byte with its
// own copy of the frame parser state and queues the expected result words.
// Each result word is then checked field by field against the oldest one.
// Both stream sides idle and stall at random.
module testbench;

    localparam time         CLK_PERIOD   = 20ns;
    localparam int          LEN_LIMIT    = 32;
    localparam int unsigned ITEM_TARGET  = 1550;
    localparam int unsigned DRAIN_AT     = 800;

    // directed opening: bad opcode zero, empty masked close, ping with all
    // rsv bits, pong with a 16-bit length, binary with a too-large length
    localparam logic [7:0] OPENING [26] = '{
        8'h00, 8'hFF,
        8'h88, 8'h80, 8'h12, 8'h34, 8'h56, 8'h78,
        8'hF9, 8'h01, 8'hFF,
        8'h0A, 8'h7E, 8'h00, 8'h01, 8'hA5,
        8'h02, 8'h7F, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // parser phases of the predicted state
    typedef enum logic [2:0] {
        PH_FIRST  = 3'd0,
        PH_SECOND = 3'd1,
        PH_EXTLEN = 3'd2,
        PH_KEY    = 3'd3,
        PH_DATA   = 3'd4
    } parse_phase_t;

    // -----------------------------------------------------------------------
    // frame parser copy and expected word store
    // -----------------------------------------------------------------------
    class deframe_checker;
        parse_phase_t parse_phase = PH_FIRST;
        logic [3:0]   ext_left    = '0;
        logic [63:0]  len_acc     = '0;
        logic [31:0]  key         = '0;
        logic [2:0]   key_left    = '0;
        logic         mask_on     = 1'b0;
        logic [7:0]   hdr         = '0;
        logic [63:0]  remaining   = '0;
        logic [1:0]   key_idx     = '0;
        wsfd_pkg::result_t expected_words [$];
        int unsigned  mismatches  = 0;

        function int unsigned pending();
            return expected_words.size();
        endfunction

        function wsfd_pkg::result_t word(wsfd_pkg::kind_t k, logic m, logic [63:0] len,
                                         logic [7:0] pb, logic last);
            wsfd_pkg::result_t r;
            r.kind           = k;
            r.fin            = hdr[7];
            r.rsv_bits       = hdr[6:4];
            r.opcode         = hdr[3:0];
            r.masked         = m;
            r.frame_length   = (len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len[31:0];
            r.payload_byte   = pb;
            r.last_in_frame  = last;
            return r;
        endfunction

        // header done: empty frame ends here, else payload follows
        function bit close_header(output wsfd_pkg::result_t r);
            if (len_acc == 0) begin
                parse_phase = PH_FIRST;
                r = word(wsfd_pkg::KIND_HEADER, mask_on, 64'd0, 8'h00, 1'b1);
            end else begin
                parse_phase = PH_DATA;
                remaining   = len_acc;
                key_idx     = '0;
                r = word(wsfd_pkg::KIND_HEADER, mask_on, len_acc, 8'h00, 1'b0);
            end
            return 1'b1;
        endfunction

        function bit after_length(output wsfd_pkg::result_t r);
            r = '0;
            if (mask_on) begin
                key_left    = wsfd_pkg::MASK_KEY_BYTES;
                parse_phase = PH_KEY;
                return 1'b0;
            end
            return close_header(r);
        endfunction

        // advance the parser by one accepted byte
        function void note_byte(logic [7:0] b);
            wsfd_pkg::result_t r;
            bit                has_word;
            logic [7:0]        kb;
            logic [3:0]        op;
            r        = '0;
            has_word = 1'b0;
            op       = hdr[3:0];
            case (parse_phase)
                PH_SECOND: begin
                    if (!(op == wsfd_pkg::OP_TEXT || op == wsfd_pkg::OP_BINARY ||
                          op == wsfd_pkg::OP_CLOSE || op == wsfd_pkg::OP_PING ||
                          op == wsfd_pkg::OP_PONG)) begin
                        parse_phase = PH_FIRST;
                        r = word(wsfd_pkg::KIND_BAD_OPCODE, 1'b0, 64'd0, 8'h00, 1'b0);
                        has_word = 1'b1;
                    end else begin
                        mask_on = b[7];
                        len_acc = '0;
                        if (b[6:0] == wsfd_pkg::LEN7_EXT64) begin
                            ext_left    = wsfd_pkg::EXT_BYTES_64;
                            parse_phase = PH_EXTLEN;
                        end else if (b[6:0] == wsfd_pkg::LEN7_EXT16) begin
                            ext_left    = wsfd_pkg::EXT_BYTES_16;
                            parse_phase = PH_EXTLEN;
                        end else begin
                            len_acc  = {57'd0, b[6:0]};
                            has_word = after_length(r);
                        end
                    end
                end
                PH_EXTLEN: begin
                    len_acc = (len_acc << 8) | {56'd0, b};
                    if (ext_left != 0)
                        ext_left = ext_left - 1'b1;
                    if (ext_left == 0) begin
                        if ((len_acc >> LEN_LIMIT) != 0) begin
                            parse_phase = PH_FIRST;
                            r = word(wsfd_pkg::KIND_TOO_LARGE, mask_on, len_acc, 8'h00,
                                     1'b0);
                            has_word = 1'b1;
                        end else begin
                            has_word = after_length(r);
                        end
                    end
                end
                PH_KEY: begin
                    key = (key << 8) | {24'd0, b};
                    if (key_left != 0)
                        key_left = key_left - 1'b1;
                    if (key_left == 0)
                        has_word = close_header(r);
                end
                PH_DATA: begin
                    // key bytes rotate from the most significant one
                    kb = mask_on ? 8'((key >> (24 - 8 * key_idx)) & 32'hFF) : 8'h00;
                    key_idx = key_idx + 1'b1;
                    if (remaining != 0)
                        remaining = remaining - 1;
                    if (remaining == 0)
                        parse_phase = PH_FIRST;
                    r = word(wsfd_pkg::KIND_PAYLOAD, mask_on, len_acc, b ^ kb,
                             remaining == 0);
                    has_word = 1'b1;
                end
                default: begin
                    hdr         = b;
                    mask_on     = 1'b0;
                    parse_phase = PH_SECOND;
                end
            endcase
            if (has_word)
                expected_words.push_back(r);
        endfunction

        function void report(string field, logic [63:0] exp_val, logic [63:0] act_val);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $realtime, field, exp_val, act_val);
        endfunction

        // compare one accepted result word with the oldest expectation
        function void check_word(logic [1:0] tuser, logic [55:0] tdata, logic tlast);
            wsfd_pkg::result_t exp_w;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result word with nothing expected, kind %0d data %0h",
                             $realtime, tuser, tdata);
                return;
            end
            exp_w = expected_words.pop_front();
            if (tuser !== exp_w.kind)
                report("result_kind", exp_w.kind, tuser);
            if (tdata[0] !== exp_w.fin)
                report("fin", exp_w.fin, tdata[0]);
            if (tdata[3:1] !== exp_w.rsv_bits)
                report("rsv_bits", exp_w.rsv_bits, tdata[3:1]);
            if (tdata[7:4] !== exp_w.opcode)
                report("opcode", exp_w.opcode, tdata[7:4]);
            if (tdata[8] !== exp_w.masked)
                report("masked", exp_w.masked, tdata[8]);
            if (tdata[40:9] !== exp_w.frame_length)
                report("frame_length", exp_w.frame_length, tdata[40:9]);
            if (tdata[48:41] !== exp_w.payload_byte)
                report("payload_byte", exp_w.payload_byte, tdata[48:41]);
            if (tlast !== exp_w.last_in_frame)
                report("last_in_frame", exp_w.last_in_frame, tlast);
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    deframe_checker sb;
    int unsigned    bytes_sent   = 0;
    bit             send_burst   = 1'b0;
    bit             ready_burst  = 1'b0;
    int unsigned    ready_wait;
    int unsigned    stall_left   = 0;

    websocket_frame_deframer_top #(
        .LENGTH_BITS (LEN_LIMIT)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // result side ready with random stalls after each word
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (m_tready) begin
            if (m_tvalid) begin
                ready_wait = ready_burst ? 0 : $urandom_range(0, 15);
                if ($urandom_range(0, 31) == 0)
                    ready_burst <= !ready_burst;
                if (ready_wait != 0) begin
                    m_tready   <= 1'b0;
                    stall_left <= ready_wait - 1;
                end
            end
        end else if (stall_left == 0) begin
            m_tready <= 1'b1;
        end else begin
            stall_left <= stall_left - 1;
        end
    end

    // result word monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_word(m_tuser, m_tdata, m_tlast);
    end

    // one byte word on the input side, with a random gap before it
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = send_burst ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // frame with random header bits, length form, key and payload, or too big
    task automatic send_frame();
        logic [7:0]  first;
        logic        msk;
        logic [6:0]  len7;
        logic [63:0] len;
        logic [31:0] mkey;
        bit          too_big;
        int unsigned pick;
        first   = 8'($urandom);
        msk     = $urandom_range(0, 1);
        too_big = 1'b0;
        case ($urandom_range(0, 4))
            0:       first[3:0] = wsfd_pkg::OP_TEXT;
            1:       first[3:0] = wsfd_pkg::OP_BINARY;
            2:       first[3:0] = wsfd_pkg::OP_CLOSE;
            3:       first[3:0] = wsfd_pkg::OP_PING;
            default: first[3:0] = wsfd_pkg::OP_PONG;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            len  = $urandom_range(0, 12);
            len7 = len[6:0];
        end else if (pick < 60) begin
            len  = $urandom_range(0, 125);
            len7 = len[6:0];
        end else if (pick < 75) begin
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(126, 300)
                                               : $urandom_range(0, 40);
            len7 = wsfd_pkg::LEN7_EXT16;
        end else if (pick < 87) begin
            len  = $urandom_range(0, 20);
            len7 = wsfd_pkg::LEN7_EXT64;
        end else begin
            len  = {$urandom, $urandom};
            len[$urandom_range(32, 63)] = 1'b1;
            if ($urandom_range(0, 3) == 0)
                len = 64'd1 << $urandom_range(32, 63);
            len7    = wsfd_pkg::LEN7_EXT64;
            too_big = 1'b1;
        end
        send_byte(first);
        send_byte({msk, len7});
        if (len7 == wsfd_pkg::LEN7_EXT16) begin
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end else if (len7 == wsfd_pkg::LEN7_EXT64) begin
            for (int i = 7; i >= 0; i--)
                send_byte(len[8 * i +: 8]);
        end
        if (!too_big) begin
            mkey = $urandom;
            if (msk) begin
                for (int i = 3; i >= 0; i--)
                    send_byte(mkey[8 * i +: 8]);
            end
            repeat (int'(len)) send_byte(8'($urandom));
        end
    endtask

    // two random header bytes, then bytes that bring the parser back to a
    // frame start without long payloads
    task automatic send_noise();
        logic [7:0] b;
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        while (sb.parse_phase != PH_FIRST) begin
            b = 8'($urandom);
            if (sb.parse_phase == PH_EXTLEN) begin
                if (sb.ext_left == wsfd_pkg::EXT_BYTES_64)
                    b = 8'($urandom_range(1, 255));
                else if (sb.ext_left == wsfd_pkg::EXT_BYTES_16)
                    b = 8'h00;
            end
            send_byte(b);
        end
    endtask

    // stimulus
    initial begin
        bit drained_mid;
        drained_mid = 1'b0;
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (OPENING[i])
            send_byte(OPENING[i]);
        drain();

        while (bytes_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 3) == 0)
                send_burst = !send_burst;
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                send_frame();
            if (!drained_mid && bytes_sent >= DRAIN_AT) begin
                drain();
                drained_mid = 1'b1;
            end
        end
        drain();
        repeat (8) @(posedge aclk);

        if (sb.mismatches == 0) begin
            $display("** websocket_frame_deframer_top: PASSED **");
        end else begin
            $display("** websocket_frame_deframer_top: FAILED **");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(600_000 * CLK_PERIOD);
        $display("** websocket_frame_deframer_top: FAILED **");
        $finish;
    end

endmodule
